[hdl/hgeh_pkg.sv]
// Shared constants, types and helper functions for the hit-gap energy histogrammer.
package hgeh_pkg;

  localparam int ENERGY_BINS  = 3000;
  localparam int TIME_BINS    = 1000;
  localparam int COUNT_WIDTH  = 32;
  localparam int OUT_WIDTH    = 32;
  localparam int THR_WIDTH    = 24;
  localparam int TIME_WIDTH   = 32;
  localparam int ENERGY_WIDTH = 16;
  localparam int INDEX_WIDTH  = 12;

  localparam int TIME_DEPTH   = TIME_BINS + 2;
  localparam int ENERGY_DEPTH = ENERGY_BINS + 2;
  localparam int TIME_AW      = $clog2(TIME_DEPTH);
  localparam int ENERGY_AW    = $clog2(ENERGY_DEPTH);
  localparam int CLR_DEPTH    = (TIME_DEPTH > ENERGY_DEPTH) ? TIME_DEPTH : ENERGY_DEPTH;
  localparam int CLR_AW       = $clog2(CLR_DEPTH);

  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

  localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(8480);

  typedef enum logic {
    CMD_HIT  = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    HIST_GAP   = 2'd0,
    HIST_SHORT = 2'd1,
    HIST_LONG  = 2'd2,
    HIST_FULL  = 2'd3
  } hist_sel_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic                 valid;
    logic                 is_read;
    logic                 pair;
    logic                 wr_short;
    logic                 wr_long;
    hist_sel_t            sel;
    logic                 bad;
    logic [TIME_AW-1:0]   taddr;
    logic [ENERGY_AW-1:0] eaddr;
  } stage_t;

  typedef struct packed {
    logic                 bad;
    logic [OUT_WIDTH-1:0] bin;
  } result_t;

  function automatic count_t sat_inc(input count_t c);
    count_t r;
    r = (c == '1) ? c : c + count_t'(1);
    return r;
  endfunction

  function automatic logic [OUT_WIDTH-1:0] clamp_out(input count_t c);
    logic [63:0] ext;
    ext = 64'(c);
    return (ext > 64'(32'hFFFF_FFFF)) ? '1 : OUT_WIDTH'(ext);
  endfunction

endpackage

[hdl/hgeh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hgeh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/hit_gap_energy_histogrammer_top.sv]
// Top level of the hit-gap energy histogrammer.
//
// Input channel (in_*): each request is either a hit (in_command = hit) or a
// read of one histogram bin (in_command = read). A request is taken at a clock
// edge where in_valid is high and in_stall is low. Hits produce no result;
// each read produces exactly one result on the out_* channel, in order.
// Hits and reads may be taken every cycle. Four histogram memories are updated
// by a two-stage read-modify-write: the address is issued in the cycle after the
// request is taken, the data returns the next cycle and is written back in the
// same cycle, with a one-entry bypass per memory covering back-to-back updates
// of the same bin. For a read, the second stage writes the result into the
// output buffer, which offers it on out_* once it reaches the head.
// Results queue in a four-entry output buffer; while the receiver holds
// out_stall, requests keep flowing until the buffer plus reads in flight
// would overflow, and only then is in_stall raised.
// After reset all memories are zeroed by a sweep of addresses, one address
// per cycle in all memories at once; in_stall stays high meanwhile.
// cfg_wr_en writes the 24-bit gap threshold; reset value is 8480.
module hit_gap_energy_histogrammer_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic                                 in_start_of_event,
  input  logic [hgeh_pkg::TIME_WIDTH-1:0]      in_hit_time,
  input  logic [hgeh_pkg::ENERGY_WIDTH-1:0]    in_hit_energy,
  input  logic [1:0]                           in_hist_select,
  input  logic [hgeh_pkg::INDEX_WIDTH-1:0]     in_bin_index,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [hgeh_pkg::OUT_WIDTH-1:0]       out_bin_count,
  output logic                                 out_bad_request,
  input  logic                                 cfg_wr_en,
  input  logic [hgeh_pkg::THR_WIDTH-1:0]       cfg_wr_data
);

  logic [hgeh_pkg::THR_WIDTH-1:0]    thr_r;
  logic [hgeh_pkg::TIME_WIDTH-1:0]   pend_time_r;
  logic [hgeh_pkg::ENERGY_WIDTH-1:0] pend_energy_r;
  logic                              pend_valid_r;

  logic                              clr_active_r;
  logic [hgeh_pkg::CLR_AW-1:0]       clr_addr_r;

  hgeh_pkg::stage_t s1_r, s1_nxt, s2_r;

  logic                              accept;
  logic                              is_read;
  logic [32:0]                       diff;
  logic                              neg;
  logic [27:0]                       ns;
  logic [hgeh_pkg::TIME_AW-1:0]      tbin;
  logic [11:0]                       kev;
  logic [hgeh_pkg::ENERGY_AW-1:0]    ebin;
  logic [31:0]                       limit;
  hgeh_pkg::hist_sel_t               sel_in;

  hgeh_pkg::count_t rd_gap, rd_short, rd_long, rd_full;
  hgeh_pkg::count_t eff_gap, eff_short, eff_long, eff_full;

  logic                              we_gap, we_short, we_long, we_full;
  logic [hgeh_pkg::TIME_AW-1:0]      wa_gap;
  logic [hgeh_pkg::ENERGY_AW-1:0]    wa_energy;
  hgeh_pkg::count_t wd_gap, wd_short, wd_long, wd_full;

  logic                              lw_gap_v_r, lw_short_v_r, lw_long_v_r, lw_full_v_r;
  logic [hgeh_pkg::TIME_AW-1:0]      lw_gap_a_r;
  logic [hgeh_pkg::ENERGY_AW-1:0]    lw_short_a_r, lw_long_a_r, lw_full_a_r;
  hgeh_pkg::count_t lw_gap_d_r, lw_short_d_r, lw_long_d_r, lw_full_d_r;

  hgeh_pkg::result_t                 fifo_r [hgeh_pkg::FIFO_DEPTH];
  logic [hgeh_pkg::FIFO_AW-1:0]      head_r, tail_r;
  logic [hgeh_pkg::FIFO_CW-1:0]      fifo_cnt_r, fifo_cnt_nxt;
  logic [hgeh_pkg::FIFO_CW-1:0]      reads_in_flight;
  logic                              push, pop;
  hgeh_pkg::result_t                 push_data;
  hgeh_pkg::count_t                  sel_count;

  assign reads_in_flight = hgeh_pkg::FIFO_CW'(s1_r.valid && s1_r.is_read)
                         + hgeh_pkg::FIFO_CW'(s2_r.valid && s2_r.is_read);
  assign in_stall = clr_active_r
                 || ((fifo_cnt_r + reads_in_flight) >= hgeh_pkg::FIFO_CW'(hgeh_pkg::FIFO_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign is_read  = (in_command == hgeh_pkg::CMD_READ);
  assign sel_in   = hgeh_pkg::hist_sel_t'(in_hist_select);

  assign diff = {1'b0, in_hit_time} - {1'b0, pend_time_r};
  assign neg  = diff[32];
  assign ns   = diff[31:4];
  assign kev  = pend_energy_r[15:4];

  always_comb begin
    if (neg) begin
      tbin = '0;
    end else if (32'(ns) < 32'(hgeh_pkg::TIME_BINS)) begin
      tbin = hgeh_pkg::TIME_AW'(32'(ns) + 32'd1);
    end else begin
      tbin = hgeh_pkg::TIME_AW'(hgeh_pkg::TIME_BINS + 1);
    end
    if (32'(kev) < 32'(hgeh_pkg::ENERGY_BINS)) begin
      ebin = hgeh_pkg::ENERGY_AW'(32'(kev) + 32'd1);
    end else begin
      ebin = hgeh_pkg::ENERGY_AW'(hgeh_pkg::ENERGY_BINS + 1);
    end
    limit = (sel_in == hgeh_pkg::HIST_GAP) ? 32'(hgeh_pkg::TIME_BINS + 1)
                                           : 32'(hgeh_pkg::ENERGY_BINS + 1);

    s1_nxt          = '0;
    s1_nxt.valid    = accept;
    s1_nxt.is_read  = is_read;
    s1_nxt.sel      = sel_in;
    if (is_read) begin
      s1_nxt.bad   = 32'(in_bin_index) > limit;
      s1_nxt.taddr = hgeh_pkg::TIME_AW'(in_bin_index);
      s1_nxt.eaddr = hgeh_pkg::ENERGY_AW'(in_bin_index);
    end else begin
      s1_nxt.pair     = !in_start_of_event && pend_valid_r;
      s1_nxt.wr_short = neg || (diff[31:0] < 32'(thr_r));
      s1_nxt.wr_long  = !neg && (diff[31:0] > 32'(thr_r));
      s1_nxt.taddr    = tbin;
      s1_nxt.eaddr    = ebin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= hgeh_pkg::THR_RESET;
      pend_time_r  <= '0;
      pend_energy_r <= '0;
      pend_valid_r <= 1'b0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_r         <= '0;
      s2_r         <= '0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (accept && !is_read) begin
        pend_time_r   <= in_hit_time;
        pend_energy_r <= in_hit_energy;
        pend_valid_r  <= 1'b1;
      end
      if (clr_active_r) begin
        if (clr_addr_r == hgeh_pkg::CLR_AW'(hgeh_pkg::CLR_DEPTH - 1)) begin
          clr_active_r <= 1'b0;
        end
        clr_addr_r <= clr_addr_r + hgeh_pkg::CLR_AW'(1);
      end
      s1_r <= s1_nxt;
      s2_r <= s1_r;
    end
  end

  assign eff_gap   = (lw_gap_v_r && lw_gap_a_r == s2_r.taddr) ? lw_gap_d_r : rd_gap;
  assign eff_short = (lw_short_v_r && lw_short_a_r == s2_r.eaddr) ? lw_short_d_r : rd_short;
  assign eff_long  = (lw_long_v_r && lw_long_a_r == s2_r.eaddr) ? lw_long_d_r : rd_long;
  assign eff_full  = (lw_full_v_r && lw_full_a_r == s2_r.eaddr) ? lw_full_d_r : rd_full;

  always_comb begin
    if (clr_active_r) begin
      we_gap    = 32'(clr_addr_r) < 32'(hgeh_pkg::TIME_DEPTH);
      we_short  = 1'b1;
      we_long   = 1'b1;
      we_full   = 1'b1;
      wa_gap    = hgeh_pkg::TIME_AW'(clr_addr_r);
      wa_energy = hgeh_pkg::ENERGY_AW'(clr_addr_r);
      wd_gap    = '0;
      wd_short  = '0;
      wd_long   = '0;
      wd_full   = '0;
    end else begin
      we_gap    = s2_r.valid && !s2_r.is_read && s2_r.pair;
      we_short  = we_gap && s2_r.wr_short;
      we_long   = we_gap && s2_r.wr_long;
      we_full   = we_gap;
      wa_gap    = s2_r.taddr;
      wa_energy = s2_r.eaddr;
      wd_gap    = hgeh_pkg::sat_inc(eff_gap);
      wd_short  = hgeh_pkg::sat_inc(eff_short);
      wd_long   = hgeh_pkg::sat_inc(eff_long);
      wd_full   = hgeh_pkg::sat_inc(eff_full);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_gap_v_r   <= 1'b0;
      lw_short_v_r <= 1'b0;
      lw_long_v_r  <= 1'b0;
      lw_full_v_r  <= 1'b0;
    end else begin
      lw_gap_v_r   <= we_gap;
      lw_short_v_r <= we_short;
      lw_long_v_r  <= we_long;
      lw_full_v_r  <= we_full;
    end
    lw_gap_a_r   <= wa_gap;
    lw_short_a_r <= wa_energy;
    lw_long_a_r  <= wa_energy;
    lw_full_a_r  <= wa_energy;
    lw_gap_d_r   <= wd_gap;
    lw_short_d_r <= wd_short;
    lw_long_d_r  <= wd_long;
    lw_full_d_r  <= wd_full;
  end

  hgeh_ram #(.WIDTH(hgeh_pkg::COUNT_WIDTH), .DEPTH(hgeh_pkg::TIME_DEPTH)) u_gap_ram (
    .clk   (clk),
    .we    (we_gap),
    .waddr (wa_gap),
    .wdata (wd_gap),
    .raddr (s1_r.taddr),
    .rdata (rd_gap)
  );

  hgeh_ram #(.WIDTH(hgeh_pkg::COUNT_WIDTH), .DEPTH(hgeh_pkg::ENERGY_DEPTH)) u_short_ram (
    .clk   (clk),
    .we    (we_short),
    .waddr (wa_energy),
    .wdata (wd_short),
    .raddr (s1_r.eaddr),
    .rdata (rd_short)
  );

  hgeh_ram #(.WIDTH(hgeh_pkg::COUNT_WIDTH), .DEPTH(hgeh_pkg::ENERGY_DEPTH)) u_long_ram (
    .clk   (clk),
    .we    (we_long),
    .waddr (wa_energy),
    .wdata (wd_long),
    .raddr (s1_r.eaddr),
    .rdata (rd_long)
  );

  hgeh_ram #(.WIDTH(hgeh_pkg::COUNT_WIDTH), .DEPTH(hgeh_pkg::ENERGY_DEPTH)) u_full_ram (
    .clk   (clk),
    .we    (we_full),
    .waddr (wa_energy),
    .wdata (wd_full),
    .raddr (s1_r.eaddr),
    .rdata (rd_full)
  );

  always_comb begin
    unique case (s2_r.sel)
      hgeh_pkg::HIST_GAP:   sel_count = eff_gap;
      hgeh_pkg::HIST_SHORT: sel_count = eff_short;
      hgeh_pkg::HIST_LONG:  sel_count = eff_long;
      hgeh_pkg::HIST_FULL:  sel_count = eff_full;
      default:              sel_count = eff_full;
    endcase
    push          = s2_r.valid && s2_r.is_read;
    push_data.bad = s2_r.bad;
    push_data.bin = s2_r.bad ? '0 : hgeh_pkg::clamp_out(sel_count);
  end

  assign out_valid       = (fifo_cnt_r != '0);
  assign pop             = out_valid && !out_stall;
  assign out_bin_count   = fifo_r[head_r].bin;
  assign out_bad_request = fifo_r[head_r].bad;
  assign fifo_cnt_nxt    = fifo_cnt_r + hgeh_pkg::FIFO_CW'(push) - hgeh_pkg::FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        tail_r <= tail_r + hgeh_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        head_r <= head_r + hgeh_pkg::FIFO_AW'(1);
      end
      fifo_cnt_r <= fifo_cnt_nxt;
    end
    if (push) begin
      fifo_r[tail_r] <= push_data;
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !accept)
    else $error("Request taken during memory clear.");

  a_fifo_room_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fifo_cnt_r < hgeh_pkg::FIFO_CW'(hgeh_pkg::FIFO_DEPTH)) || pop)
    else $error("Result pushed into a full output buffer.");

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= hgeh_pkg::FIFO_CW'(hgeh_pkg::FIFO_DEPTH))
    else $error("Output buffer count out of range.");

  a_split_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(we_short && we_long && !clr_active_r))
    else $error("Short-gap and long-gap bins updated by one hit.");

endmodule

[tb/sv/tb_hit_gap_energy_histogrammer_top.sv]
// Self-checking testbench for the hit-gap energy histogrammer top level.
`timescale 1ns / 100ps

module tb_hit_gap_energy_histogrammer_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam int LONG_HOLD    = 300;

  typedef struct {
    hgeh_pkg::cmd_t                    cmd;
    logic                              soe;
    logic [hgeh_pkg::TIME_WIDTH-1:0]   t;
    logic [hgeh_pkg::ENERGY_WIDTH-1:0] e;
    hgeh_pkg::hist_sel_t               sel;
    logic [hgeh_pkg::INDEX_WIDTH-1:0]  idx;
  } request_t;

  typedef struct {
    logic [hgeh_pkg::OUT_WIDTH-1:0] count;
    logic                           bad;
  } bin_reply_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              in_command = 1'b0;
  logic                              in_start_of_event = 1'b0;
  logic [hgeh_pkg::TIME_WIDTH-1:0]   in_hit_time = '0;
  logic [hgeh_pkg::ENERGY_WIDTH-1:0] in_hit_energy = '0;
  logic [1:0]                        in_hist_select = '0;
  logic [hgeh_pkg::INDEX_WIDTH-1:0]  in_bin_index = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [hgeh_pkg::OUT_WIDTH-1:0]    out_bin_count;
  logic                              out_bad_request;
  logic                              cfg_wr_en = 1'b0;
  logic [hgeh_pkg::THR_WIDTH-1:0]    cfg_wr_data = '0;

  request_t   request_q[$];
  bin_reply_t due_counts[$];
  request_t   offered;
  bit         offering = 1'b0;
  bit         quiet = 1'b0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  int         holds_asked = 0;
  int         holds_done = 0;
  int         mismatches = 0;
  int         cycles = 0;

  logic [hgeh_pkg::THR_WIDTH-1:0]    threshold = hgeh_pkg::THR_RESET;
  logic [hgeh_pkg::TIME_WIDTH-1:0]   held_time = '0;
  logic [hgeh_pkg::ENERGY_WIDTH-1:0] held_energy = '0;
  bit                                have_held = 1'b0;
  hgeh_pkg::count_t                  gap_hist[hgeh_pkg::TIME_DEPTH];
  hgeh_pkg::count_t                  short_hist[hgeh_pkg::ENERGY_DEPTH];
  hgeh_pkg::count_t                  long_hist[hgeh_pkg::ENERGY_DEPTH];
  hgeh_pkg::count_t                  full_hist[hgeh_pkg::ENERGY_DEPTH];
  logic [hgeh_pkg::TIME_WIDTH-1:0]   gen_time = '0;

  hit_gap_energy_histogrammer_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_start_of_event (in_start_of_event),
    .in_hit_time       (in_hit_time),
    .in_hit_energy     (in_hit_energy),
    .in_hist_select    (in_hist_select),
    .in_bin_index      (in_bin_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_bin_count     (out_bin_count),
    .out_bad_request   (out_bad_request),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always #6 clk = ~clk;

  function automatic hgeh_pkg::count_t count_up(input hgeh_pkg::count_t c);
    return (c == '1) ? c : c + hgeh_pkg::count_t'(1);
  endfunction

  function automatic int energy_slot(input logic [hgeh_pkg::ENERGY_WIDTH-1:0] e);
    int kev;
    kev = int'(e >> 4);
    return (kev < hgeh_pkg::ENERGY_BINS) ? kev + 1 : hgeh_pkg::ENERGY_BINS + 1;
  endfunction

  function automatic int gap_slot(input longint gap);
    longint ns;
    if (gap < 0) begin
      return 0;
    end
    ns = gap >> 4;
    return (ns < hgeh_pkg::TIME_BINS) ? int'(ns) + 1 : hgeh_pkg::TIME_BINS + 1;
  endfunction

  function automatic void tally_request(input request_t r);
    longint     gap;
    int         eb;
    int         tb;
    int         lim;
    bin_reply_t x;
    if (r.cmd == hgeh_pkg::CMD_HIT) begin
      if (!r.soe && have_held) begin
        gap = longint'({32'd0, r.t}) - longint'({32'd0, held_time});
        eb = energy_slot(held_energy);
        tb = gap_slot(gap);
        gap_hist[tb] = count_up(gap_hist[tb]);
        if (gap < longint'({40'd0, threshold})) begin
          short_hist[eb] = count_up(short_hist[eb]);
        end else if (gap > longint'({40'd0, threshold})) begin
          long_hist[eb] = count_up(long_hist[eb]);
        end
        full_hist[eb] = count_up(full_hist[eb]);
      end
      held_time = r.t;
      held_energy = r.e;
      have_held = 1'b1;
    end else begin
      lim = (r.sel == hgeh_pkg::HIST_GAP) ? hgeh_pkg::TIME_BINS + 1
                                          : hgeh_pkg::ENERGY_BINS + 1;
      x.bad = 1'b0;
      if (int'(r.idx) > lim) begin
        x.count = '0;
        x.bad = 1'b1;
      end else begin
        case (r.sel)
          hgeh_pkg::HIST_GAP:   x.count = gap_hist[r.idx];
          hgeh_pkg::HIST_SHORT: x.count = short_hist[r.idx];
          hgeh_pkg::HIST_LONG:  x.count = long_hist[r.idx];
          default:              x.count = full_hist[r.idx];
        endcase
      end
      due_counts.push_back(x);
    end
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [hgeh_pkg::OUT_WIDTH-1:0] got,
                                 input logic [hgeh_pkg::OUT_WIDTH-1:0] want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
  endtask

  task automatic push_hit(input logic soe, input logic [hgeh_pkg::TIME_WIDTH-1:0] t,
                          input logic [hgeh_pkg::ENERGY_WIDTH-1:0] e);
    request_t r;
    r.cmd = hgeh_pkg::CMD_HIT;
    r.soe = soe;
    r.t = t;
    r.e = e;
    r.sel = hgeh_pkg::hist_sel_t'($urandom_range(0, 3));
    r.idx = hgeh_pkg::INDEX_WIDTH'($urandom_range(0, 4095));
    request_q.push_back(r);
  endtask

  task automatic push_read(input hgeh_pkg::hist_sel_t sel, input int idx);
    request_t r;
    r.cmd = hgeh_pkg::CMD_READ;
    r.soe = 1'($urandom_range(0, 1));
    r.t = $urandom;
    r.e = hgeh_pkg::ENERGY_WIDTH'($urandom);
    r.sel = sel;
    r.idx = hgeh_pkg::INDEX_WIDTH'(idx);
    request_q.push_back(r);
  endtask

  task automatic queue_random(input int n, input int read_pct);
    int                                k;
    int                                idx;
    logic                              soe;
    logic [hgeh_pkg::TIME_WIDTH-1:0]   delta;
    logic [hgeh_pkg::ENERGY_WIDTH-1:0] e;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < read_pct) begin
        k = $urandom_range(0, 99);
        if (k < 35) begin
          idx = $urandom_range(0, 10);
        end else if (k < 45) begin
          idx = int'(threshold >> 4) + $urandom_range(0, 2);
          if (idx > 4095) begin
            idx = $urandom_range(0, 4095);
          end
        end else if (k < 75) begin
          idx = $urandom_range(0, hgeh_pkg::TIME_BINS + 1);
        end else if (k < 88) begin
          idx = $urandom_range(0, hgeh_pkg::ENERGY_BINS + 2);
        end else begin
          idx = $urandom_range(0, 4095);
        end
        push_read(hgeh_pkg::hist_sel_t'($urandom_range(0, 3)), idx);
      end else begin
        soe = ($urandom_range(0, 99) < 12);
        k = $urandom_range(0, 99);
        if (k < 25) begin
          delta = {8'd0, threshold} + $urandom_range(0, 2) - 32'd1;
        end else if (k < 70) begin
          delta = $urandom_range(0, 17000);
        end else if (k < 80) begin
          delta = 32'd0 - $urandom_range(1, 2000);
        end else if (k < 90) begin
          delta = $urandom;
        end else begin
          delta = '0;
        end
        gen_time = gen_time + delta;
        k = $urandom_range(0, 99);
        if (k < 40) begin
          e = hgeh_pkg::ENERGY_WIDTH'($urandom_range(0, 127));
        end else if (k < 85) begin
          e = hgeh_pkg::ENERGY_WIDTH'($urandom_range(0, 47999));
        end else begin
          e = hgeh_pkg::ENERGY_WIDTH'($urandom_range(48000, 65535));
        end
        push_hit(soe, gen_time, e);
      end
    end
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || offering || due_counts.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [hgeh_pkg::THR_WIDTH-1:0] v);
    wait_drained();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    threshold = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        tally_request(offered);
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 14);
        end else if (request_q.size() != 0) begin
          offered = request_q.pop_front();
          offering = 1'b1;
          in_command <= offered.cmd;
          in_start_of_event <= offered.soe;
          in_hit_time <= offered.t;
          in_hit_energy <= offered.e;
          in_hist_select <= offered.sel;
          in_bin_index <= offered.idx;
        end
      end
      in_valid <= offering;
    end
  end

  always @(posedge clk) begin
    bin_reply_t want;
    logic       stall_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_counts.size() == 0) begin
          report_mismatch("unexpected result, count", out_bin_count, '0);
        end else begin
          want = due_counts.pop_front();
          if (out_bin_count !== want.count) begin
            report_mismatch("bin_count", out_bin_count, want.count);
          end
          if (out_bad_request !== want.bad) begin
            report_mismatch("bad_request", hgeh_pkg::OUT_WIDTH'(out_bad_request),
                            hgeh_pkg::OUT_WIDTH'(want.bad));
          end
        end
      end
      if (holds_asked != holds_done) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      stall_next = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 14);
        stall_next = 1'b1;
      end
      out_stall <= stall_next;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    foreach (gap_hist[i]) gap_hist[i] = '0;
    foreach (short_hist[i]) short_hist[i] = '0;
    foreach (long_hist[i]) long_hist[i] = '0;
    foreach (full_hist[i]) full_hist[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_read(hgeh_pkg::HIST_GAP, 0);
    push_hit(1'b0, 32'd0, 16'd0);
    push_hit(1'b0, 32'd80, 16'd0);
    push_hit(1'b0, 32'd8560, 16'hFFFF);
    push_hit(1'b0, 32'd17041, 16'd47999);
    push_hit(1'b0, 32'd17025, 16'd15);
    push_hit(1'b1, 32'hFFFF_FFFF, 16'd48000);
    push_hit(1'b0, 32'd0, 16'd100);
    push_hit(1'b0, 32'd16000, 16'd200);
    push_hit(1'b0, 32'd31999, 16'd300);
    push_read(hgeh_pkg::HIST_GAP, 0);
    push_read(hgeh_pkg::HIST_GAP, hgeh_pkg::TIME_BINS + 1);
    push_read(hgeh_pkg::HIST_GAP, hgeh_pkg::TIME_BINS + 2);
    push_read(hgeh_pkg::HIST_GAP, 6);
    push_read(hgeh_pkg::HIST_GAP, hgeh_pkg::TIME_BINS);
    push_read(hgeh_pkg::HIST_SHORT, 1);
    push_read(hgeh_pkg::HIST_SHORT, hgeh_pkg::ENERGY_BINS + 2);
    push_read(hgeh_pkg::HIST_LONG, hgeh_pkg::ENERGY_BINS + 1);
    push_read(hgeh_pkg::HIST_LONG, 1);
    push_read(hgeh_pkg::HIST_FULL, 1);
    push_read(hgeh_pkg::HIST_FULL, hgeh_pkg::ENERGY_BINS + 1);
    push_read(hgeh_pkg::HIST_FULL, 4095);
    push_read(hgeh_pkg::HIST_FULL, hgeh_pkg::ENERGY_BINS);

    set_threshold('0);
    queue_random(120, 30);
    set_threshold('1);
    queue_random(100, 30);
    set_threshold(hgeh_pkg::THR_WIDTH'(4160));
    holds_asked <= holds_asked + 1;
    queue_random(120, 80);
    set_threshold(hgeh_pkg::THR_WIDTH'($urandom));
    queue_random(150, 30);
    set_threshold(hgeh_pkg::THR_RESET);
    quiet <= 1'b1;
    queue_random(160, 30);

    wait_drained();
    if (due_counts.size() != 0) begin
      report_mismatch("results never seen", hgeh_pkg::OUT_WIDTH'(due_counts.size()), '0);
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
hdl/hgeh_pkg.sv
hdl/hgeh_ram.sv
hdl/hit_gap_energy_histogrammer_top.sv
tb/sv/tb_hit_gap_energy_histogrammer_top.sv
